@@ sv/lsh_pkg.sv @@
// Shared types and constants for the 3x3 Laplacian sharpening filter.
package lsh_pkg;

  localparam int unsigned PixW      = 8;
  localparam int unsigned ColW      = 10;
  localparam int unsigned RowW      = 16;
  localparam int unsigned WidthRegW = 11;
  localparam int unsigned CfgW      = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned SumW      = 11;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MinDim    = 3;
  localparam int unsigned ResetW    = 640;
  localparam int unsigned ResetH    = 480;
  localparam int unsigned PixMax    = 255;

  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = 2;
  localparam int unsigned QCntW     = 3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth  = 2'd0,
    CfgImageHeight = 2'd1
  } cfg_idx_e;

  // One pixel with its column neighbors from the line stores and its position.
  typedef struct packed {
    logic [PixW-1:0] top;
    logic [PixW-1:0] mid;
    logic [PixW-1:0] pix;
    logic [RowW-1:0] row;
    logic [ColW-1:0] col;
    logic            produce;
    logic            last;
  } item_t;

endpackage

@@ sv/lsh_front.sv @@
// Front end: frame counters, configuration registers and the two line stores.
module lsh_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lsh_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          pixel_valid_i,
  output logic                          pixel_stall_o,
  input  logic [lsh_pkg::PixW-1:0]      pixel_i,
  input  logic [lsh_pkg::QCntW-1:0]     q_count_i,
  output logic                          push_o,
  output lsh_pkg::item_t                push_item_o,
  output logic                          restart_o
);

  logic [lsh_pkg::ColW-1:0]      w_last_q, w_last_d;
  logic [lsh_pkg::RowW-1:0]      h_last_q, h_last_d;
  logic [lsh_pkg::ColW-1:0]      col_q, col_d;
  logic [lsh_pkg::RowW-1:0]      row_q, row_d;
  logic                          a_valid_q;
  logic [lsh_pkg::PixW-1:0]      a_pix_q;
  logic [lsh_pkg::ColW-1:0]      a_col_q;
  logic [lsh_pkg::RowW-1:0]      a_row_q;
  logic                          a_produce_q;
  logic                          a_last_q;
  logic [lsh_pkg::PixW-1:0]      top_rd_q;
  logic [lsh_pkg::PixW-1:0]      mid_rd_q;
  logic [lsh_pkg::PixW-1:0]      upper_mem [lsh_pkg::MaxWidth];
  logic [lsh_pkg::PixW-1:0]      middle_mem [lsh_pkg::MaxWidth];
  logic                          accept;
  logic                          col_end;
  logic                          row_end;
  logic [lsh_pkg::WidthRegW-1:0] raw_w;
  logic [lsh_pkg::WidthRegW-1:0] eff_w;
  logic [lsh_pkg::RowW-1:0]      eff_h;

  // Room is counted for the item already in the read stage.
  assign pixel_stall_o = (q_count_i + lsh_pkg::QCntW'(a_valid_q))
                         >= lsh_pkg::QCntW'(lsh_pkg::QDepth);
  assign accept  = pixel_valid_i && !pixel_stall_o;
  assign col_end = (col_q == w_last_q);
  assign row_end = (row_q == h_last_q);

  always_comb begin
    raw_w    = cfg_data_i[lsh_pkg::WidthRegW-1:0];
    eff_w    = raw_w;
    eff_h    = cfg_data_i;
    w_last_d = w_last_q;
    h_last_d = h_last_q;
    restart_o = 1'b0;
    if (raw_w < lsh_pkg::WidthRegW'(lsh_pkg::MinDim)) begin
      eff_w = lsh_pkg::WidthRegW'(lsh_pkg::MinDim);
    end else if (raw_w > lsh_pkg::WidthRegW'(lsh_pkg::MaxWidth)) begin
      eff_w = lsh_pkg::WidthRegW'(lsh_pkg::MaxWidth);
    end
    if (cfg_data_i < lsh_pkg::RowW'(lsh_pkg::MinDim)) begin
      eff_h = lsh_pkg::RowW'(lsh_pkg::MinDim);
    end
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        lsh_pkg::CfgImageWidth: begin
          w_last_d  = lsh_pkg::ColW'(eff_w - lsh_pkg::WidthRegW'(1));
          restart_o = 1'b1;
        end
        lsh_pkg::CfgImageHeight: begin
          h_last_d  = eff_h - lsh_pkg::RowW'(1);
          restart_o = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_o) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      col_d = col_end ? '0 : col_q + lsh_pkg::ColW'(1);
      if (col_end) begin
        row_d = row_end ? '0 : row_q + lsh_pkg::RowW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q  <= lsh_pkg::ColW'(lsh_pkg::ResetW - 1);
      h_last_q  <= lsh_pkg::RowW'(lsh_pkg::ResetH - 1);
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
    end else begin
      w_last_q  <= w_last_d;
      h_last_q  <= h_last_d;
      col_q     <= col_d;
      row_q     <= row_d;
      a_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_pix_q     <= pixel_i;
      a_col_q     <= col_q;
      a_row_q     <= row_q;
      a_produce_q <= (row_q >= lsh_pkg::RowW'(2)) && (col_q >= lsh_pkg::ColW'(2));
      a_last_q    <= col_end && row_end;
    end
  end

  // Middle store: read the old entry and overwrite it with the new pixel.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mid_rd_q            <= middle_mem[col_q];
      middle_mem[col_q]   <= pixel_i;
    end
  end

  // Upper store: the displaced middle entry is written in the cycle after its read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_rd_q <= upper_mem[col_q];
    end
    if (a_valid_q) begin
      upper_mem[a_col_q] <= mid_rd_q;
    end
  end

  assign push_o = a_valid_q;

  always_comb begin
    push_item_o.top     = top_rd_q;
    push_item_o.mid     = mid_rd_q;
    push_item_o.pix     = a_pix_q;
    push_item_o.row     = a_row_q - lsh_pkg::RowW'(1);
    push_item_o.col     = a_col_q - lsh_pkg::ColW'(1);
    push_item_o.produce = a_produce_q;
    push_item_o.last    = a_last_q;
  end

endmodule

@@ sv/lsh_queue.sv @@
// Short queue between the front end and the filter back end.
module lsh_queue (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  lsh_pkg::item_t            push_item_i,
  input  logic                      pop_i,
  output logic                      valid_o,
  output lsh_pkg::item_t            item_o,
  output logic [lsh_pkg::QCntW-1:0] count_o
);

  lsh_pkg::item_t             slots_q [lsh_pkg::QDepth];
  logic [lsh_pkg::QPtrW-1:0]  wr_ptr_q;
  logic [lsh_pkg::QPtrW-1:0]  rd_ptr_q;
  logic [lsh_pkg::QCntW-1:0]  count_q, count_d;

  assign valid_o = (count_q != '0);
  assign item_o  = slots_q[rd_ptr_q];
  assign count_o = count_q;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + lsh_pkg::QCntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - lsh_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + lsh_pkg::QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + lsh_pkg::QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < lsh_pkg::QCntW'(lsh_pkg::QDepth))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue pop while empty");
  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < lsh_pkg::QCntW'(lsh_pkg::QDepth)
      |-> lsh_pkg::QPtrW'(wr_ptr_q - rd_ptr_q) == count_q[lsh_pkg::QPtrW-1:0])
    else $error("queue pointers disagree with count");
`endif

endmodule

@@ sv/lsh_back.sv @@
// Back end: 3x3 window, Laplacian sum, clamp and result register.
module lsh_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     restart_i,
  input  logic                     q_valid_i,
  input  lsh_pkg::item_t           q_item_i,
  output logic                     pop_o,
  output logic                     result_valid_o,
  input  logic                     result_stall_i,
  output logic [lsh_pkg::PixW-1:0] sharpened_o,
  output logic [lsh_pkg::RowW-1:0] out_row_o,
  output logic [lsh_pkg::ColW-1:0] out_col_o,
  output logic                     frame_last_o
);

  logic [lsh_pkg::PixW-1:0] win_q [6];
  logic                     out_valid_q;
  logic [lsh_pkg::PixW-1:0] out_pix_q;
  logic [lsh_pkg::RowW-1:0] out_row_q;
  logic [lsh_pkg::ColW-1:0] out_col_q;
  logic                     out_last_q;
  logic [lsh_pkg::SumW-1:0] nsum;
  logic [lsh_pkg::SumW-1:0] centre8;
  logic [lsh_pkg::SumW-1:0] diff;
  logic [lsh_pkg::PixW-1:0] clamped;

  assign pop_o = q_valid_i && (!out_valid_q || !result_stall_i);

  always_comb begin
    nsum = lsh_pkg::SumW'(win_q[0]) + lsh_pkg::SumW'(win_q[1])
         + lsh_pkg::SumW'(win_q[2]) + lsh_pkg::SumW'(win_q[3])
         + lsh_pkg::SumW'(win_q[5]) + lsh_pkg::SumW'(q_item_i.top)
         + lsh_pkg::SumW'(q_item_i.mid) + lsh_pkg::SumW'(q_item_i.pix);
    centre8 = {win_q[4], 3'b000};
    diff    = centre8 - nsum;
    if (centre8 < nsum) begin
      clamped = '0;
    end else if (diff > lsh_pkg::SumW'(lsh_pkg::PixMax)) begin
      clamped = lsh_pkg::PixW'(lsh_pkg::PixMax);
    end else begin
      clamped = diff[lsh_pkg::PixW-1:0];
    end
  end

  // Advance the window by one column on every popped item; a restart clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (restart_i) begin
      for (int i = 0; i < 6; i++) begin
        win_q[i] <= '0;
      end
    end else if (pop_o) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= q_item_i.top;
      win_q[4] <= q_item_i.mid;
      win_q[5] <= q_item_i.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= q_item_i.produce;
    end else if (!result_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && q_item_i.produce) begin
      out_pix_q  <= clamped;
      out_row_q  <= q_item_i.row;
      out_col_q  <= q_item_i.col;
      out_last_q <= q_item_i.last;
    end
  end

  assign result_valid_o = out_valid_q;
  assign sharpened_o    = out_pix_q;
  assign out_row_o      = out_row_q;
  assign out_col_o      = out_col_q;
  assign frame_last_o   = out_last_q;

`ifndef ASSERT_OFF
  a_hold_when_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_stall_i |=> out_valid_q && $stable(out_pix_q))
    else $error("result dropped while stalled");
  a_no_pop_over_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && result_stall_i |-> !pop_o)
    else $error("item popped over a stalled result");
  a_last_is_produced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && q_item_i.last |-> q_item_i.produce)
    else $error("frame end marked on a border pixel");
`endif

endmodule

@@ sv/laplacian_sharpen_3x3.sv @@
// A pixel's result is registered through the line-store read stage, the queue and the
// result register, starting when its right neighbor below arrives.
// Throughput: one pixel per cycle while pixel_stall_o is low; the queue and result register decouple stalls.
// Reset: counters and window zero, width 640, height 480; line stores are not
// cleared, each entry is written in the first two rows before its value is used.
module laplacian_sharpen_3x3 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lsh_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lsh_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          pixel_valid_i,
  output logic                          pixel_stall_o,
  input  logic [lsh_pkg::PixW-1:0]      pixel_i,
  output logic                          result_valid_o,
  input  logic                          result_stall_i,
  output logic [lsh_pkg::PixW-1:0]      sharpened_o,
  output logic [lsh_pkg::RowW-1:0]      out_row_o,
  output logic [lsh_pkg::ColW-1:0]      out_col_o,
  output logic                          frame_last_o
);

  logic                      push;
  lsh_pkg::item_t            push_item;
  logic                      pop;
  logic                      q_valid;
  lsh_pkg::item_t            q_item;
  logic [lsh_pkg::QCntW-1:0] q_count;
  logic                      restart;

  lsh_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_stall_o (pixel_stall_o),
    .pixel_i       (pixel_i),
    .q_count_i     (q_count),
    .push_o        (push),
    .push_item_o   (push_item),
    .restart_o     (restart)
  );

  lsh_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .count_o     (q_count)
  );

  lsh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .restart_i      (restart),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .sharpened_o    (sharpened_o),
    .out_row_o      (out_row_o),
    .out_col_o      (out_col_o),
    .frame_last_o   (frame_last_o)
  );

endmodule
